>>> design/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants of the escape-time pixel block
// field widths, register codes and reset values, palette constants, beat
// structs and the state types of the sequencers
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int COORD_BITS = 12;
	localparam int COUNT_BITS = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_EDGE   = 3'd0,
		CFG_TOP_EDGE    = 3'd1,
		CFG_COLUMN_STEP = 3'd2,
		CFG_ROW_STEP    = 3'd3,
		CFG_ITER_LIMIT  = 3'd4
	} cfg_index_t;

	localparam logic signed [31:0] RST_LEFT_EDGE   = 32'shD8000000;
	localparam logic signed [31:0] RST_TOP_EDGE    = 32'sh13333333;
	localparam logic [30:0]        RST_COLUMN_STEP = 31'd626349;
	localparam logic [30:0]        RST_ROW_STEP    = 31'd920350;
	localparam logic [COUNT_BITS-1:0] RST_ITER_LIMIT = 16'd256;

	// palette: t is a 16 bit fraction, u = 1 - t needs 17 bits
	localparam int T_BITS    = 16;
	localparam int V_BITS    = 17;
	localparam int DIV_STEPS = 16;
	localparam int MUL_STEPS = 4;
	localparam logic [V_BITS-1:0] ONE_T   = 17'h10000;
	localparam logic [V_BITS-1:0] K_RED   = 17'd2295;
	localparam logic [V_BITS-1:0] K_GREEN = 17'd3825;
	localparam logic [V_BITS-1:0] K_BLUE  = 17'd4335;

	typedef struct packed {
		logic [COORD_BITS-1:0] column;
		logic [COORD_BITS-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] iterations;
		logic                  inside_res;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
	} result_t;

	typedef struct packed {
		logic                  done;
		logic                  in_set;
		logic [COUNT_BITS-1:0] count;
	} step_stat_t;

	typedef struct packed {
		logic       done;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pal_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_ITER,
		ST_PAL,
		ST_FIN
	} top_state_t;

	typedef enum logic [1:0] {
		STP_IDLE,
		STP_MUL,
		STP_UPD
	} step_state_t;

	typedef enum logic [1:0] {
		PAL_IDLE,
		PAL_DIV,
		PAL_MUL
	} pal_state_t;

	// clamp a palette value to 8 bits
	function automatic logic [7:0] sat8(input logic [17:0] v);
		logic [7:0] r;
		if (v > 18'd255) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

>>> design/mep_map.sv
// ----------------------------------------------------------------------------
// mep_map: pixel to complex point
// two stages: column and row times step, then edge offset and saturation
// ----------------------------------------------------------------------------
module mep_map import mep_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [COORD_BITS-1:0]         column,
	input  logic [COORD_BITS-1:0]         row,
	input  logic signed [31:0]            left_edge,
	input  logic signed [31:0]            top_edge,
	input  logic [30:0]                   column_step,
	input  logic [30:0]                   row_step,
	output logic                          done,
	output logic signed [FRAC_BITS+3:0]   c_re,
	output logic signed [FRAC_BITS+3:0]   c_im
);

	localparam int W   = FRAC_BITS + 4;
	localparam int PRW = COORD_BITS + 31;
	localparam int SW  = (W > PRW + 2) ? W : PRW + 2;
	localparam logic signed [SW-1:0] CMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] CMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	logic [PRW-1:0]        pcol_s1;
	logic [PRW-1:0]        prow_s1;
	logic                  valid_s1;
	logic                  done_q;
	logic signed [W-1:0]   c_re_q;
	logic signed [W-1:0]   c_im_q;
	logic signed [SW-1:0]  sum_re;
	logic signed [SW-1:0]  sum_im;

	function automatic logic [W-1:0] sat_c(input logic signed [SW-1:0] v);
		logic [W-1:0] r;
		if (v > CMAX) begin
			r = CMAX[W-1:0];
		end else if (v < CMIN) begin
			r = CMIN[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= go;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pcol_s1 <= PRW'(column) * PRW'(column_step);
			prow_s1 <= PRW'(row) * PRW'(row_step);
		end
		if (valid_s1) begin
			c_re_q <= sat_c(sum_re);
			c_im_q <= sat_c(sum_im);
		end
	end

	// exact sums, one saturation at the end
	assign sum_re = {{(SW-32){left_edge[31]}}, left_edge} + {{(SW-PRW){1'b0}}, pcol_s1};
	assign sum_im = {{(SW-32){top_edge[31]}}, top_edge} - {{(SW-PRW){1'b0}}, prow_s1};

	assign done = done_q;
	assign c_re = c_re_q;
	assign c_im = c_im_q;

endmodule

>>> design/mep_step.sv
// ----------------------------------------------------------------------------
// mep_step: shared complex square-and-add unit
// one z = z*z + c pass per iteration: the digit products accumulate in the
// STP_MUL state, then scaling, escape test and saturated update follow in the
// STP_UPD state
module mep_step import mep_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [FRAC_BITS+3:0]   c_re,
	input  logic signed [FRAC_BITS+3:0]   c_im,
	input  logic [COUNT_BITS-1:0]         iter_limit,
	output step_stat_t                    stat
);

	localparam int W    = FRAC_BITS + 4;
	localparam int ND   = (W + 31) / 32;
	localparam int DW   = (W + ND - 1) / ND;
	localparam int PADW = ND * DW;
	localparam int AW   = 2 * PADW;
	localparam int NP   = ND * ND;
	localparam int PCW  = (NP > 1) ? $clog2(NP) : 1;
	localparam int SHW  = $clog2(AW);

	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};
	localparam logic signed [AW:0]  QMAX = {{(AW+2-W){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [AW:0]  QMIN = {{(AW+2-W){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W:0]          FOUR = {2'b00, 1'b1, {(FRAC_BITS+2){1'b0}}};

	step_state_t          state_q;
	step_state_t          state_d;
	logic                 done_d;
	logic [PCW-1:0]       pc_q;
	logic                 pc_last;
	logic [PCW-1:0]       di;
	logic [PCW-1:0]       dj;
	logic [SHW-1:0]       shamt;

	logic signed [W-1:0]  x_q;
	logic signed [W-1:0]  y_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [AW-1:0]        acc_xx_q;
	logic [AW-1:0]        acc_yy_q;
	logic [AW-1:0]        acc_xy_q;

	logic [W-1:0]         mx;
	logic [W-1:0]         my;
	logic [PADW-1:0]      mx_pad;
	logic [PADW-1:0]      my_pad;
	logic [2*DW-1:0]      prod_xx;
	logic [2*DW-1:0]      prod_yy;
	logic [2*DW-1:0]      prod_xy;

	logic [AW-1:0]        qxx;
	logic [AW-1:0]        qyy;
	logic signed [AW:0]   pxy;
	logic signed [AW:0]   qxy;
	logic [W-1:0]         xx;
	logic [W-1:0]         yy;
	logic [W-1:0]         xy;
	logic [W:0]           sumsq;
	logic signed [W:0]    dd;
	logic signed [W+1:0]  ee;
	logic signed [W+1:0]  ff;
	logic [W-1:0]         nx;
	logic [W-1:0]         ny;
	logic                 stop;

	function automatic logic [W-1:0] sat_w(input logic signed [W+1:0] v);
		logic [W-1:0] r;
		if (v > SMAX) begin
			r = MAXV;
		end else if (v < SMIN) begin
			r = MINV;
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	// digit products on magnitudes
	assign mx     = x_q[W-1] ? W'(-x_q) : W'(x_q);
	assign my     = y_q[W-1] ? W'(-y_q) : W'(y_q);
	assign mx_pad = PADW'(mx);
	assign my_pad = PADW'(my);
	assign di     = PCW'(pc_q / ND);
	assign dj     = PCW'(pc_q % ND);
	assign shamt  = SHW'((32'(di) + 32'(dj)) * DW);
	assign pc_last = (pc_q == PCW'(NP - 1));

	assign prod_xx = mx_pad[di*DW +: DW] * mx_pad[dj*DW +: DW];
	assign prod_yy = my_pad[di*DW +: DW] * my_pad[dj*DW +: DW];
	assign prod_xy = mx_pad[di*DW +: DW] * my_pad[dj*DW +: DW];

	// scaling with floor toward minus infinity and saturation
	always_comb begin
		qxx = acc_xx_q >> FRAC_BITS;
		qyy = acc_yy_q >> FRAC_BITS;
		xx  = (qxx > AW'(MAXV)) ? MAXV : qxx[W-1:0];
		yy  = (qyy > AW'(MAXV)) ? MAXV : qyy[W-1:0];
		pxy = (x_q[W-1] ^ y_q[W-1]) ? -$signed({1'b0, acc_xy_q}) : $signed({1'b0, acc_xy_q});
		qxy = pxy >>> (FRAC_BITS - 1);
		if (qxy > QMAX) begin
			xy = MAXV;
		end else if (qxy < QMIN) begin
			xy = MINV;
		end else begin
			xy = qxy[W-1:0];
		end
		sumsq = {1'b0, xx} + {1'b0, yy};
		stop  = (sumsq > FOUR) || (n_q >= iter_limit);
		dd    = $signed({1'b0, xx}) - $signed({1'b0, yy});
		ee    = {dd[W], dd} + {{2{c_re[W-1]}}, c_re};
		ff    = {{2{xy[W-1]}}, xy} + {{2{c_im[W-1]}}, c_im};
		nx    = sat_w(ee);
		ny    = sat_w(ff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STP_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == STP_MUL) begin
				pc_q <= pc_last ? '0 : pc_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			STP_IDLE: begin
				if (start) begin
					state_d = STP_MUL;
				end
			end
			STP_MUL: begin
				if (pc_last) begin
					state_d = STP_UPD;
				end
			end
			STP_UPD: begin
				done_d  = stop;
				state_d = stop ? STP_IDLE : STP_MUL;
			end
			default: state_d = STP_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == STP_IDLE && start) begin
			x_q <= '0;
			y_q <= '0;
			n_q <= '0;
		end else if (state_q == STP_UPD && !stop) begin
			x_q <= nx;
			y_q <= ny;
			n_q <= n_q + 1'b1;
		end
		if (state_q == STP_MUL) begin
			acc_xx_q <= ((pc_q == '0) ? '0 : acc_xx_q) + (AW'(prod_xx) << shamt);
			acc_yy_q <= ((pc_q == '0) ? '0 : acc_yy_q) + (AW'(prod_yy) << shamt);
			acc_xy_q <= ((pc_q == '0) ? '0 : acc_xy_q) + (AW'(prod_xy) << shamt);
		end
	end

	assign stat.done   = done_d;
	assign stat.count  = n_q;
	assign stat.in_set = (n_q == iter_limit);

endmodule

>>> design/mep_palette.sv
// ----------------------------------------------------------------------------
// mep_palette: polynomial colour of an escaped point
// restoring division for t = count/limit, one quotient bit a cycle, then four
// multiply steps in three colour lanes
// ----------------------------------------------------------------------------
module mep_palette import mep_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_BITS-1:0]  count,
	input  logic [COUNT_BITS-1:0]  iter_limit,
	output pal_stat_t              stat
);

	localparam int CW = $clog2(DIV_STEPS);

	pal_state_t               state_q;
	pal_state_t               state_d;
	logic [CW-1:0]            cnt_q;
	logic                     done_q;
	logic [COUNT_BITS-1:0]    rem_q;
	logic [T_BITS-1:0]        quo_q;
	logic [COUNT_BITS:0]      r2;
	logic [COUNT_BITS:0]      r2_sub;
	logic                     ge;

	logic [V_BITS-1:0]        t17;
	logic [V_BITS-1:0]        u17;
	logic [V_BITS-1:0]        rv_q;
	logic [V_BITS-1:0]        gv_q;
	logic [V_BITS-1:0]        bv_q;
	logic [V_BITS-1:0]        ra;
	logic [V_BITS-1:0]        rb;
	logic [V_BITS-1:0]        ga;
	logic [V_BITS-1:0]        gb;
	logic [V_BITS-1:0]        ba;
	logic [V_BITS-1:0]        bb;
	logic [2*V_BITS-1:0]      rp;
	logic [2*V_BITS-1:0]      gp;
	logic [2*V_BITS-1:0]      bp;
	logic [7:0]               red_q;
	logic [7:0]               green_q;
	logic [7:0]               blue_q;
	logic                     div_last;
	logic                     mul_last;

	// one restoring division step
	assign r2     = {rem_q, 1'b0};
	assign ge     = (r2 >= {1'b0, iter_limit});
	assign r2_sub = r2 - {1'b0, iter_limit};

	assign t17 = {1'b0, quo_q};
	assign u17 = ONE_T - t17;

	assign div_last = (cnt_q == CW'(DIV_STEPS - 1));
	assign mul_last = (cnt_q == CW'(MUL_STEPS - 1));

	// lane operands per multiply step
	always_comb begin
		ra = rv_q;
		ga = gv_q;
		ba = bv_q;
		unique case (cnt_q[1:0])
			2'd0: begin
				ra = t17; rb = t17;
				ga = t17; gb = u17;
				ba = u17; bb = u17;
			end
			2'd1: begin
				rb = t17;
				gb = t17;
				bb = u17;
			end
			2'd2: begin
				rb = u17;
				gb = u17;
				bb = t17;
			end
			default: begin
				rb = K_RED;
				gb = K_GREEN;
				bb = K_BLUE;
			end
		endcase
		rp = ra * rb;
		gp = ga * gb;
		bp = ba * bb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PAL_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == PAL_MUL) && mul_last;
			if (state_q == PAL_IDLE || (state_q == PAL_DIV && div_last) ||
			    (state_q == PAL_MUL && mul_last)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PAL_IDLE: begin
				if (start) begin
					state_d = PAL_DIV;
				end
			end
			PAL_DIV: begin
				if (div_last) begin
					state_d = PAL_MUL;
				end
			end
			PAL_MUL: begin
				if (mul_last) begin
					state_d = PAL_IDLE;
				end
			end
			default: state_d = PAL_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == PAL_IDLE && start) begin
			rem_q <= count;
			quo_q <= '0;
		end else if (state_q == PAL_DIV) begin
			rem_q <= ge ? r2_sub[COUNT_BITS-1:0] : r2[COUNT_BITS-1:0];
			quo_q <= {quo_q[T_BITS-2:0], ge};
		end
		if (state_q == PAL_MUL) begin
			if (mul_last) begin
				red_q   <= sat8(rp[33:16]);
				green_q <= sat8(gp[33:16]);
				blue_q  <= sat8({1'b0, bp[33:17]});
			end else begin
				rv_q <= rp[32:16];
				gv_q <= gp[32:16];
				bv_q <= bp[32:16];
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.red   = red_q;
	assign stat.green = green_q;
	assign stat.blue  = blue_q;

endmodule

>>> design/mandelbrot_escape_pixel_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top: escape-time evaluator for one pixel
// maps a pixel to c, iterates z = z*z + c in signed fixed point with
// saturation at +-8, returns the count, the inside flag and a palette colour
// ----------------------------------------------------------------------------
//  channel  dir  handshake                beat
//  pix      in   pix_valid / pix_stall    pixel_t  (column, row)
//  res      out  res_valid / res_stall    result_t (iterations, inside, rgb)
//  cfg      in   cfg_write                cfg_index, cfg_data (no read-back)
//
//  the palette runs only when the point escapes; the step unit splits each
//  factor into ND = ceil((FRAC_BITS + 4) / 32) digits and accumulates their
//  ND*ND digit products once per iteration
//  reset clears the sequencers, the output valid and the registers to defaults
//  one pixel at a time: pix_stall is high from accept until the result moves
//  into the output register, which holds one finished beat under res_stall
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top import mep_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pixel_t                pix,
	output logic                  res_valid,
	input  logic                  res_stall,
	output result_t               res,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int W = FRAC_BITS + 4;

	// configuration registers
	logic signed [31:0]       left_edge_q;
	logic signed [31:0]       top_edge_q;
	logic [30:0]              column_step_q;
	logic [30:0]              row_step_q;
	logic [COUNT_BITS-1:0]    iter_limit_q;

	top_state_t               state_q;
	top_state_t               state_d;
	logic                     map_go;
	logic                     step_start;
	logic                     pal_start;
	logic                     res_load;

	logic                     map_done;
	logic signed [W-1:0]      c_re;
	logic signed [W-1:0]      c_im;
	step_stat_t               step_stat;
	pal_stat_t                pal_stat;

	logic                     res_valid_q;
	result_t                  res_q;
	result_t                  res_d;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q   <= RST_LEFT_EDGE;
			top_edge_q    <= RST_TOP_EDGE;
			column_step_q <= RST_COLUMN_STEP;
			row_step_q    <= RST_ROW_STEP;
			iter_limit_q  <= RST_ITER_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LEFT_EDGE:   left_edge_q   <= cfg_data;
				CFG_TOP_EDGE:    top_edge_q    <= cfg_data;
				CFG_COLUMN_STEP: column_step_q <= cfg_data[30:0];
				CFG_ROW_STEP:    row_step_q    <= cfg_data[30:0];
				CFG_ITER_LIMIT:  iter_limit_q  <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// coordinate mapping
	mep_map #(
		.FRAC_BITS(FRAC_BITS)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (map_go),
		.column     (pix.column),
		.row        (pix.row),
		.left_edge  (left_edge_q),
		.top_edge   (top_edge_q),
		.column_step(column_step_q),
		.row_step   (row_step_q),
		.done       (map_done),
		.c_re       (c_re),
		.c_im       (c_im)
	);

	// iteration loop, c stays in the map outputs for the whole pixel
	mep_step #(
		.FRAC_BITS(FRAC_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (step_start),
		.c_re      (c_re),
		.c_im      (c_im),
		.iter_limit(iter_limit_q),
		.stat      (step_stat)
	);

	// colour only for escaped points, so the divisor is never zero here
	mep_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pal_start),
		.count     (step_stat.count),
		.iter_limit(iter_limit_q),
		.stat      (pal_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pixel sequencer
	always_comb begin
		state_d    = state_q;
		map_go     = 1'b0;
		step_start = 1'b0;
		pal_start  = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					map_go  = 1'b1;
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				if (map_done) begin
					step_start = 1'b1;
					state_d    = ST_ITER;
				end
			end
			ST_ITER: begin
				if (step_stat.done) begin
					if (step_stat.in_set) begin
						state_d = ST_FIN;
					end else begin
						pal_start = 1'b1;
						state_d   = ST_PAL;
					end
				end
			end
			ST_PAL: begin
				if (pal_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// output register free or being emptied this cycle
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// count and inside flag stay in the step unit until the next pixel
	always_comb begin
		res_d.iterations = step_stat.count;
		res_d.inside_res = step_stat.in_set;
		res_d.red        = step_stat.in_set ? 8'd0 : pal_stat.red;
		res_d.green      = step_stat.in_set ? 8'd0 : pal_stat.green;
		res_d.blue       = step_stat.in_set ? 8'd0 : pal_stat.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign pix_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// inside points leave black
	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.inside_res |->
			(res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0))
		else $error("inside point with nonzero colour");

	// an accepted beat starts the mapping
	a_accept_map: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> state_q == ST_MAP)
		else $error("accepted pixel did not enter mapping");

	// the step unit reports only while the sequencer waits on it
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_stat.done |-> state_q == ST_ITER)
		else $error("step unit finished outside iteration phase");

	// the palette reports only while the sequencer waits on it
	a_pal_done: assert property (@(posedge clk) disable iff (!arst_n)
		pal_stat.done |-> state_q == ST_PAL)
		else $error("palette finished outside colour phase");

endmodule
